// File: design/i2cbb_pkg.sv
package i2cbb_pkg;

	// Bus command codes
	localparam logic [2:0] CMD_IDLE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_RESTART = 3'd3;
	localparam logic [2:0] CMD_ACK     = 3'd4;
	localparam logic [2:0] CMD_NACK    = 3'd5;
	localparam logic [2:0] CMD_ACKCLK  = 3'd6;
	localparam logic [2:0] CMD_WAKEUP  = 3'd7;

	// Hold markers
	localparam logic [1:0] HOLD_NONE  = 2'd0;
	localparam logic [1:0] HOLD_SHORT = 2'd1;
	localparam logic [1:0] HOLD_LONG  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_SHORT_HOLD = 1'b0;
	localparam logic CFG_LONG_HOLD  = 1'b1;

	localparam int BYTE_W = 8;

	// Fixed pin-step runs shared by the commands and the wakeup write
	typedef enum logic [2:0] {
		SEQ_START,
		SEQ_STOP,
		SEQ_ACK,
		SEQ_NACK,
		SEQ_ACKCLK,
		SEQ_ACKSLOT
	} seq_t;

	typedef struct packed {
		logic             wake;
		seq_t             seq;
		logic [BYTE_W-1:0] data_byte;
	} q_item_t;

	typedef struct packed {
		logic on_scl;
		logic level;
	} step_op_t;

	// Two bits per step, step 0 in the low bits: {on_scl, level}
	localparam logic [7:0] TBL_START   = 8'b10_00_11_01;
	localparam logic [7:0] TBL_STOP    = 8'b01_11_00_10;
	localparam logic [7:0] TBL_ACK     = 8'b01_10_11_00;
	localparam logic [7:0] TBL_NACK    = 8'b00_00_11_01;
	localparam logic [7:0] TBL_ACKCLK  = 8'b00_00_10_11;
	localparam logic [7:0] TBL_ACKSLOT = 8'b00_10_11_01;

	function automatic step_op_t seq_op(input seq_t s, input logic [1:0] k);
		logic [7:0] t;
		case (s)
			SEQ_START:   t = TBL_START;
			SEQ_STOP:    t = TBL_STOP;
			SEQ_ACK:     t = TBL_ACK;
			SEQ_NACK:    t = TBL_NACK;
			SEQ_ACKCLK:  t = TBL_ACKCLK;
			SEQ_ACKSLOT: t = TBL_ACKSLOT;
			default:     t = TBL_START;
		endcase
		return step_op_t'(t[{k, 1'b0} +: 2]);
	endfunction

	function automatic logic [1:0] seq_last_k(input seq_t s);
		logic [1:0] k;
		case (s)
			SEQ_NACK:   k = 2'd1;
			SEQ_ACKCLK: k = 2'd1;
			default:    k = 2'd3;
		endcase
		return k;
	endfunction

endpackage

// File: design/i2cbb_front.sv
module i2cbb_front import i2cbb_pkg::*; (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              q_full,
	output logic              push,
	output q_item_t           item
);

	logic is_idle;

	always_comb begin
		item.wake      = 1'b0;
		item.seq       = SEQ_START;
		item.data_byte = byte_value;
		is_idle        = 1'b0;
		case (command)
			CMD_IDLE:    is_idle = 1'b1;
			CMD_START:   item.seq = SEQ_START;
			CMD_RESTART: item.seq = SEQ_START;
			CMD_STOP:    item.seq = SEQ_STOP;
			CMD_ACK:     item.seq = SEQ_ACK;
			CMD_NACK:    item.seq = SEQ_NACK;
			CMD_ACKCLK:  item.seq = SEQ_ACKCLK;
			CMD_WAKEUP:  item.wake = 1'b1;
			default:     is_idle = 1'b1;
		endcase
	end

	assign in_ready = !q_full;
	// drop idle requests: they emit nothing
	assign push = in_valid && in_ready && !is_idle;

endmodule

// File: design/i2cbb_queue.sv
module i2cbb_queue import i2cbb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t wr_item,
	output logic    full,
	input  logic    pop,
	output logic    rd_valid,
	output q_item_t rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("pop from an empty queue");

endmodule

// File: design/i2cbb_back.sv
module i2cbb_back import i2cbb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  q_item_t    q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl,
	output logic       sda,
	output logic [1:0] hold,
	output logic       last
);

	typedef enum logic [2:0] {
		SEG_INIT,
		SEG_SEQ,
		SEG_SCL0,
		SEG_BITS,
		SEG_LONG
	} seg_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_RISE,
		PH_FALL
	} phase_t;

	logic              busy_q;
	seg_t              seg_q;
	seq_t              seq_q;
	logic              wake_q;
	logic [1:0]        k_q;
	phase_t            ph_q;
	logic [2:0]        bit_q;
	logic [BYTE_W-1:0] byte_q;
	logic              scl_q;
	logic              sda_q;
	logic [1:0]        hold_q;
	logic              last_q;
	logic              vld_q;

	seg_t              n_seg;
	seq_t              n_seq;
	logic [1:0]        n_k;
	phase_t            n_ph;
	logic [2:0]        n_bit;
	logic [BYTE_W-1:0] n_byte;
	logic              n_scl;
	logic              n_sda;
	logic [1:0]        n_hold;
	logic              fin;
	logic              adv;
	step_op_t          op;

	always_comb begin
		n_seg  = seg_q;
		n_seq  = seq_q;
		n_k    = k_q;
		n_ph   = ph_q;
		n_bit  = bit_q;
		n_byte = byte_q;
		n_scl  = scl_q;
		n_sda  = sda_q;
		n_hold = HOLD_SHORT;
		fin    = 1'b0;
		op     = seq_op(seq_q, k_q);
		case (seg_q)
			SEG_INIT: begin
				n_scl  = 1'b1;
				n_sda  = 1'b1;
				n_hold = HOLD_NONE;
				n_seg  = SEG_SEQ;
				n_seq  = SEQ_START;
				n_k    = '0;
			end
			SEG_SEQ: begin
				if (op.on_scl) begin
					n_scl = op.level;
				end else begin
					n_sda = op.level;
				end
				if (k_q == seq_last_k(seq_q)) begin
					n_k = '0;
					// chain the wakeup segments, otherwise the run ends here
					if (wake_q && seq_q == SEQ_START) begin
						n_seg = SEG_SCL0;
					end else if (seq_q == SEQ_ACKSLOT) begin
						n_seg = SEG_LONG;
					end else begin
						fin = 1'b1;
					end
				end else begin
					n_k = k_q + 2'd1;
				end
			end
			SEG_SCL0: begin
				n_scl = 1'b0;
				n_seg = SEG_BITS;
				n_ph  = PH_DATA;
				n_bit = '0;
			end
			SEG_BITS: begin
				case (ph_q)
					PH_DATA: begin
						n_sda = byte_q[BYTE_W-1];
						n_ph  = PH_RISE;
					end
					PH_RISE: begin
						n_scl = 1'b1;
						n_ph  = PH_FALL;
					end
					default: begin
						n_scl  = 1'b0;
						n_ph   = PH_DATA;
						n_byte = {byte_q[BYTE_W-2:0], 1'b0};
						n_bit  = bit_q + 3'd1;
						if (bit_q == 3'(BYTE_W - 1)) begin
							n_seg = SEG_SEQ;
							n_seq = SEQ_ACKSLOT;
							n_k   = '0;
						end
					end
				endcase
			end
			SEG_LONG: begin
				n_hold = HOLD_LONG;
				n_seg  = SEG_SEQ;
				n_seq  = SEQ_STOP;
				n_k    = '0;
			end
			default: begin
				n_seg = SEG_INIT;
			end
		endcase
	end

	assign adv   = !vld_q || out_ready;
	assign q_pop = q_valid && adv && (!busy_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q  <= 1'b0;
			seg_q  <= SEG_INIT;
			seq_q  <= SEQ_START;
			wake_q <= 1'b0;
			k_q    <= '0;
			ph_q   <= PH_DATA;
			bit_q  <= '0;
			byte_q <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			hold_q <= HOLD_NONE;
			last_q <= 1'b0;
		end else if (adv) begin
			vld_q <= busy_q;
			if (busy_q) begin
				scl_q  <= n_scl;
				sda_q  <= n_sda;
				hold_q <= n_hold;
				last_q <= fin;
				seg_q  <= n_seg;
				seq_q  <= n_seq;
				k_q    <= n_k;
				ph_q   <= n_ph;
				bit_q  <= n_bit;
				byte_q <= n_byte;
			end
			// load the next request right behind the last step of this one
			if (q_pop) begin
				busy_q <= 1'b1;
				wake_q <= q_item.wake;
				seq_q  <= q_item.seq;
				byte_q <= q_item.data_byte;
				k_q    <= '0;
				seg_q  <= q_item.wake ? SEG_INIT : SEG_SEQ;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_valid = vld_q;
	assign scl       = scl_q;
	assign sda       = sda_q;
	assign hold      = hold_q;
	assign last      = last_q;

	a_init_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && hold_q == HOLD_NONE |-> scl_q && sda_q)
		else $error("line init step without both lines high");

	a_long_after_ack: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && hold_q == HOLD_LONG |-> !scl_q && !sda_q)
		else $error("long hold with a line released");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> vld_q && last_q)
		else $error("sequencer went idle without a final step");

endmodule

// File: design/i2c_bitbang_condition_generator.sv
// Entry: with the sequencer idle, a request passes the queue, the sequencer load and the
// output register before its first pin step shows; later requests follow their
// predecessor's last step with no gap. Throughput: one pin step per cycle from the
// step sequencer unless out_ready stalls; bus conditions have 2 or 4 steps, wakeup 39.
// Reset: both lines return high, the queue and output register empty, holds back to 2.
module i2c_bitbang_condition_generator import i2cbb_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	input  logic [BYTE_W-1:0] byte_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              scl,
	output logic              sda,
	output logic [1:0]        hold,
	output logic              last
);

	logic       short_hold_q;
	logic [7:0] short_hold_val_q;
	logic [7:0] long_hold_ms_q;
	logic       q_full;
	logic       push;
	q_item_t    wr_item;
	logic       pop;
	logic       rd_valid;
	q_item_t    rd_item;

	// hold lengths are kept for the pin driver; they do not change the step run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_hold_val_q <= 8'd2;
			long_hold_ms_q   <= 8'd2;
			short_hold_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_HOLD: begin
					short_hold_val_q <= cfg_data;
					short_hold_q     <= 1'b1;
				end
				CFG_LONG_HOLD:  long_hold_ms_q <= cfg_data;
				default:        short_hold_q   <= short_hold_q;
			endcase
		end
	end

	i2cbb_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.byte_value (byte_value),
		.q_full     (q_full),
		.push       (push),
		.item       (wr_item)
	);

	i2cbb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_item  (rd_item)
	);

	i2cbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (rd_valid),
		.q_item    (rd_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl       (scl),
		.sda       (sda),
		.hold      (hold),
		.last      (last)
	);

	a_short_cfg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_we && cfg_index == CFG_SHORT_HOLD) |=> $stable(short_hold_val_q))
		else $error("short hold changed without a write");

	a_long_cfg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_we && cfg_index == CFG_LONG_HOLD) |=> $stable(long_hold_ms_q))
		else $error("long hold changed without a write");

	a_short_written: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(short_hold_q) |-> $past(cfg_we) && $past(cfg_index) == CFG_SHORT_HOLD)
		else $error("short hold marked written without a write");

endmodule
